// ===== src/nkrp_pkg.sv =====
// Package for the NTS-KE record stream parser.
// Holds the result codes, register index and the front-to-back queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package nkrp_pkg;

  // result_kind codes
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // register word index of end_record_type
  localparam logic REG_END_TYPE = 1'b0;

  localparam logic [14:0] TYPE_MASK    = 15'h7FFF;
  localparam logic [1:0]  HEADER_LAST  = 2'd3;  // index of the fourth header byte

  // first result carried by a queue entry
  typedef enum logic [1:0] {
    PRIM_NONE   = 2'd0,
    PRIM_HEADER = 2'd1,
    PRIM_BODY   = 2'd2
  } prim_e;

  // all results caused by one input byte
  typedef struct packed {
    prim_e       prim;
    logic        crit;
    logic [14:0] rtype;
    logic [15:0] blen;
    logic [7:0]  data;
    logic        has_status;
    logic        ok;
  } entry_t;

endpackage

// ===== src/nkrp_front.sv =====
// Front end of the NTS-KE record parser: accepts stream bytes, tracks the record
// state and builds one queue entry per byte that causes results.
// Depends on nkrp_pkg.
`timescale 1ns / 1ps

module nkrp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [14:0]         end_type_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          stream_byte_i,
  input  logic                stream_end_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output nkrp_pkg::entry_t    q_entry_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [23:0] hold_q, hold_d;
  logic [15:0] rem_q, rem_d;
  logic        ending_q, ending_d;

  logic        accept;
  logic [15:0] tf;
  logic [15:0] blen;
  logic [15:0] rem_dec;
  logic        is_end;
  nkrp_pkg::entry_t ent;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign tf      = hold_q[23:8];
  assign blen    = {hold_q[7:0], stream_byte_i};
  assign is_end  = ((tf[14:0] & nkrp_pkg::TYPE_MASK) == end_type_i);
  assign rem_dec = rem_q - 16'd1;

  // next state and entry for the current byte
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hold_d   = hold_q;
    rem_d    = rem_q;
    ending_d = ending_q;

    ent            = '0;
    ent.prim       = nkrp_pkg::PRIM_NONE;
    ent.has_status = 1'b0;
    ent.ok         = 1'b0;

    unique case (phase_q)
      PH_HEADER: begin
        if (cnt_q != nkrp_pkg::HEADER_LAST) begin
          hold_d = {hold_q[15:0], stream_byte_i};
          cnt_d  = cnt_q + 2'd1;
          if (stream_end_i) begin
            phase_d = PH_HEADER; cnt_d = '0; hold_d = '0; rem_d = '0; ending_d = 1'b0;
            ent.has_status = 1'b1;
          end
        end else begin
          ent.prim  = nkrp_pkg::PRIM_HEADER;
          ent.crit  = tf[15];
          ent.rtype = tf[14:0];
          ent.blen  = blen;
          cnt_d     = '0;
          hold_d    = '0;
          if (blen == 16'd0) begin
            // empty body: record completes here
            if (is_end) begin
              ent.has_status = 1'b1;
              ent.ok         = 1'b1;
              if (stream_end_i) begin
                phase_d = PH_HEADER; rem_d = '0; ending_d = 1'b0;
              end else begin
                phase_d = PH_DONE;
              end
            end else begin
              phase_d = PH_HEADER; rem_d = '0; ending_d = 1'b0;
              ent.has_status = stream_end_i;
            end
          end else if (stream_end_i) begin
            phase_d = PH_HEADER; rem_d = '0; ending_d = 1'b0;
            ent.has_status = 1'b1;
          end else begin
            phase_d  = PH_BODY;
            rem_d    = blen;
            ending_d = is_end;
          end
        end
      end
      PH_BODY: begin
        ent.prim = nkrp_pkg::PRIM_BODY;
        ent.data = stream_byte_i;
        rem_d    = rem_dec;
        if (rem_dec == 16'd0) begin
          if (ending_q) begin
            ent.has_status = 1'b1;
            ent.ok         = 1'b1;
            if (stream_end_i) begin
              phase_d = PH_HEADER; cnt_d = '0; hold_d = '0; ending_d = 1'b0;
            end else begin
              phase_d = PH_DONE;
            end
          end else begin
            phase_d = PH_HEADER; cnt_d = '0; hold_d = '0; ending_d = 1'b0;
            ent.has_status = stream_end_i;
          end
        end else if (stream_end_i) begin
          phase_d = PH_HEADER; cnt_d = '0; hold_d = '0; rem_d = '0; ending_d = 1'b0;
          ent.has_status = 1'b1;
        end
      end
      default: begin
        // done phase: drop bytes until the stream ends
        if (stream_end_i) begin
          phase_d = PH_HEADER; cnt_d = '0; hold_d = '0; rem_d = '0; ending_d = 1'b0;
        end
      end
    endcase
  end

  assign q_entry_o = ent;
  assign q_push_o  = accept && ((ent.prim != nkrp_pkg::PRIM_NONE) || ent.has_status);

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= '0;
      hold_q   <= '0;
      rem_q    <= '0;
      ending_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      hold_q   <= hold_d;
      rem_q    <= rem_d;
      ending_q <= ending_d;
    end
  end

endmodule

// ===== src/nkrp_queue.sv =====
// Short FIFO of result entries between parser front and result back end.
// Depends on nkrp_pkg.
`timescale 1ns / 1ps

module nkrp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nkrp_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output nkrp_pkg::entry_t  head_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  nkrp_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ===== src/nkrp_back.sv =====
// Back end of the NTS-KE record parser: takes queue entries and sends their
// one or two results out, one beat per cycle while out_ready_i is high.
// Depends on nkrp_pkg.
`timescale 1ns / 1ps

module nkrp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nkrp_pkg::entry_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic              flag_critical_o,
  output logic [14:0]       record_type_o,
  output logic [15:0]       body_length_o,
  output logic [7:0]        body_byte_o,
  output logic              stream_ok_o,
  output logic              last_result_o
);

  nkrp_pkg::entry_t cur_q;
  logic             valid_q;
  logic             second_q;  // presenting the status result
  logic             beat, finish;

  assign beat   = valid_q && out_ready_i;
  assign finish = second_q || !cur_q.has_status;
  assign pop_o  = !empty_i && (!valid_q || (beat && finish));

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (pop_o) begin
      valid_q  <= 1'b1;
      second_q <= (head_i.prim == nkrp_pkg::PRIM_NONE);
    end else if (beat) begin
      if (finish) begin
        valid_q <= 1'b0;
      end else begin
        second_q <= 1'b1;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // result decode; unused fields are zero
  always_comb begin
    result_kind_o   = nkrp_pkg::KIND_STATUS;
    flag_critical_o = 1'b0;
    record_type_o   = '0;
    body_length_o   = '0;
    body_byte_o     = '0;
    stream_ok_o     = 1'b0;
    last_result_o   = 1'b1;
    if (second_q) begin
      stream_ok_o = cur_q.ok;
    end else if (cur_q.prim == nkrp_pkg::PRIM_HEADER) begin
      result_kind_o   = nkrp_pkg::KIND_HEADER;
      flag_critical_o = cur_q.crit;
      record_type_o   = cur_q.rtype;
      body_length_o   = cur_q.blen;
      last_result_o   = !cur_q.has_status;
    end else begin
      result_kind_o = nkrp_pkg::KIND_BODY;
      body_byte_o   = cur_q.data;
      last_result_o = !cur_q.has_status;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== src/nts_ke_record_stream_parser.sv =====
// Top level of the NTS-KE record stream parser: APB register, parser front,
// result queue and result back end.
// Depends on nkrp_pkg, nkrp_front, nkrp_queue, nkrp_back.
//
//  channel  | direction | handshake             | beat
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid_i/in_ready_o | one stream byte + end flag
//  out      | output    | out_valid_o/out_ready_i | one result (header/body/status)
//  apb      | input     | psel/penable/pready   | end_record_type write/read
//
// Cycles: one byte is taken per cycle while the queue has room; each byte
// causes zero, one or two results, and the back end sends one result per cycle
// while out_ready_i is high. The QUEUE_DEPTH-entry queue absorbs output stalls;
// in_ready_o drops only when it is full. Reset: async active low, parser
// returns to the header phase and end_record_type clears to 0.
`timescale 1ns / 1ps

module nts_ke_record_stream_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_end_i,
  // results out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic        flag_critical_o,
  output logic [14:0] record_type_o,
  output logic [15:0] body_length_o,
  output logic [7:0]  body_byte_o,
  output logic        stream_ok_o,
  output logic        last_result_o
);

  logic [14:0]      end_type_q;
  logic             reg_hit;
  logic             q_push, q_pop, q_full, q_empty;
  nkrp_pkg::entry_t q_in, q_head;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == nkrp_pkg::REG_END_TYPE);
  assign prdata  = reg_hit ? {17'd0, end_type_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_type_q <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      end_type_q <= pwdata[14:0];
    end
  end

  nkrp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .end_type_i    (end_type_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .stream_end_i  (stream_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  nkrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  nkrp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .flag_critical_o (flag_critical_o),
    .record_type_o   (record_type_o),
    .body_length_o   (body_length_o),
    .body_byte_o     (body_byte_o),
    .stream_ok_o     (stream_ok_o),
    .last_result_o   (last_result_o)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for nts_ke_record_stream_parser.
// Predicts header, body and status results from the byte stream and checks each beat.
// Depends on nkrp_pkg and the parser top level.
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 40;
  localparam logic [2:0] END_TYPE_ADDR = {nkrp_pkg::REG_END_TYPE, 2'b00};

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_BODY   = 2'd1,
    PHASE_DONE   = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        crit;
    logic [14:0] rtype;
    logic [15:0] blen;
    logic [7:0]  data;
    logic        ok;
    logic        last;
  } parse_result_t;

  // DUT ports
  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i;
  logic        stream_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic        flag_critical_o;
  logic [14:0] record_type_o;
  logic [15:0] body_length_o;
  logic [7:0]  body_byte_o;
  logic        stream_ok_o;
  logic        last_result_o;

  // parser state as predicted
  parse_phase_e model_phase      = PHASE_HEADER;
  logic [1:0]   model_hdr_count  = 2'd0;
  logic [23:0]  model_hdr_hold   = 24'd0;
  logic [15:0]  model_body_left  = 16'd0;
  logic         model_end_record = 1'b0;
  logic [14:0]  model_end_type   = 15'd0;

  parse_result_t pending_results[$];
  logic [7:0]    stream_q[$];

  logic [14:0] active_end_type = 15'd0;
  int          sent_items      = 0;
  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  int          hold_left       = 0;
  bit          sender_quiet    = 1'b0;
  bit          receiver_quiet  = 1'b0;

  nts_ke_record_stream_parser u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .flag_critical_o(flag_critical_o),
    .record_type_o  (record_type_o),
    .body_length_o  (body_length_o),
    .body_byte_o    (body_byte_o),
    .stream_ok_o    (stream_ok_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic parse_result_t make_result(input logic [1:0] kind, input logic crit,
                                                input logic [14:0] rtype,
                                                input logic [15:0] blen,
                                                input logic [7:0] data, input logic ok);
    parse_result_t r;
    r.kind  = kind;
    r.crit  = crit;
    r.rtype = rtype;
    r.blen  = blen;
    r.data  = data;
    r.ok    = ok;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic parse_result_t status_result(input logic ok);
    return make_result(nkrp_pkg::KIND_STATUS, 1'b0, 15'd0, 16'd0, 8'd0, ok);
  endfunction

  task automatic clear_parser();
    model_phase      = PHASE_HEADER;
    model_hdr_count  = 2'd0;
    model_hdr_hold   = 24'd0;
    model_body_left  = 16'd0;
    model_end_record = 1'b0;
  endtask

  // a record is complete: ok and skip the rest, or move on / fail on stream end
  task automatic close_record(input logic is_end, input logic last);
    if (is_end) begin
      pending_results.push_back(status_result(1'b1));
      if (last) clear_parser();
      else model_phase = PHASE_DONE;
    end else begin
      clear_parser();
      if (last) pending_results.push_back(status_result(1'b0));
    end
  endtask

  task automatic predict_parse(input logic [7:0] b, input logic last);
    int            base;
    logic [15:0]   tf;
    logic [15:0]   blen;
    logic          is_end;
    parse_result_t tail;
    base = pending_results.size();
    case (model_phase)
      PHASE_HEADER: begin
        if (model_hdr_count != nkrp_pkg::HEADER_LAST) begin
          model_hdr_hold  = {model_hdr_hold[15:0], b};
          model_hdr_count = model_hdr_count + 2'd1;
          if (last) begin
            clear_parser();
            pending_results.push_back(status_result(1'b0));
          end
        end else begin
          tf     = model_hdr_hold[23:8];
          blen   = {model_hdr_hold[7:0], b};
          is_end = (tf[14:0] == model_end_type);
          pending_results.push_back(make_result(nkrp_pkg::KIND_HEADER, tf[15], tf[14:0],
                                                blen, 8'd0, 1'b0));
          model_hdr_count = 2'd0;
          model_hdr_hold  = 24'd0;
          if (blen == 16'd0) begin
            close_record(is_end, last);
          end else if (last) begin
            clear_parser();
            pending_results.push_back(status_result(1'b0));
          end else begin
            model_phase      = PHASE_BODY;
            model_body_left  = blen;
            model_end_record = is_end;
          end
        end
      end
      PHASE_BODY: begin
        pending_results.push_back(make_result(nkrp_pkg::KIND_BODY, 1'b0, 15'd0, 16'd0, b,
                                              1'b0));
        model_body_left = model_body_left - 16'd1;
        if (model_body_left == 16'd0) begin
          close_record(model_end_record, last);
        end else if (last) begin
          clear_parser();
          pending_results.push_back(status_result(1'b0));
        end
      end
      default: begin
        // past the end record: bytes are dropped until the stream ends
        if (last) clear_parser();
      end
    endcase
    if (pending_results.size() > base) begin
      tail      = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[cycle %0d] mismatch on %s: got 0x%0h, want 0x%0h",
               cycle_count, what, got, want);
  endtask

  task automatic compare_result();
    parse_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with nothing pending", 32'(result_kind_o), 32'd0);
      return;
    end
    want = pending_results.pop_front();
    if (result_kind_o !== want.kind)
      report_mismatch("result_kind", 32'(result_kind_o), 32'(want.kind));
    if (flag_critical_o !== want.crit)
      report_mismatch("flag_critical", 32'(flag_critical_o), 32'(want.crit));
    if (record_type_o !== want.rtype)
      report_mismatch("record_type", 32'(record_type_o), 32'(want.rtype));
    if (body_length_o !== want.blen)
      report_mismatch("body_length", 32'(body_length_o), 32'(want.blen));
    if (body_byte_o !== want.data)
      report_mismatch("body_byte", 32'(body_byte_o), 32'(want.data));
    if (stream_ok_o !== want.ok)
      report_mismatch("stream_ok", 32'(stream_ok_o), 32'(want.ok));
    if (last_result_o !== want.last)
      report_mismatch("last_result", 32'(last_result_o), 32'(want.last));
  endtask

  // one process sees register writes, input beats and output beats in that order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == END_TYPE_ADDR)
        model_end_type = pwdata[14:0];
      if (in_valid_i && in_ready_o) predict_parse(stream_byte_i, stream_end_i);
      if (out_valid_o && out_ready_i) compare_result();
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, forced hold-off, or always ready
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (receiver_quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= 9);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_beat(input logic [7:0] b, input logic last);
    if (!sender_quiet && $urandom_range(99, 0) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    stream_end_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
  endtask

  // send the built stream, flag on its last byte
  task automatic send_stream();
    foreach (stream_q[i]) send_beat(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // stop sending and wait until every pending result has come out
  task automatic drain_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write end_record_type with junk in the upper bits, then read it back
  task automatic set_end_type(input logic [14:0] value);
    logic [31:0] wdata;
    logic [31:0] rdata;
    drain_idle();
    wdata       = $urandom;
    wdata[14:0] = value;
    apb_access(1'b1, END_TYPE_ADDR, wdata, rdata);
    apb_access(1'b0, END_TYPE_ADDR, 32'd0, rdata);
    if (rdata[14:0] !== value)
      report_mismatch("end_record_type readback", rdata, 32'(value));
    active_end_type = value;
  endtask

  // ---------------------------------------------------------------- stream builders

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [14:0] other_type();
    logic [14:0] t;
    t = 15'($urandom);
    if (t == active_end_type) t[0] = ~t[0];
    return t;
  endfunction

  task automatic add_header(input logic crit, input logic [14:0] rtype,
                            input logic [15:0] len);
    stream_q.push_back({crit, rtype[14:8]});
    stream_q.push_back(rtype[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
  endtask

  task automatic add_record(input logic crit, input logic [14:0] rtype, input int len);
    add_header(crit, rtype, len[15:0]);
    repeat (len) stream_q.push_back(rand_byte());
  endtask

  // mostly well-formed messages; some cut short, unterminated or pure noise
  task automatic random_stream();
    int pick;
    int cut;
    pick = $urandom_range(99, 0);
    if (pick >= 93) begin
      repeat ($urandom_range(12, 1)) stream_q.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(3, 0))
        add_record(1'($urandom_range(1, 0)), other_type(), $urandom_range(6, 0));
      if (pick < 78) begin
        add_record(1'($urandom_range(1, 0)), active_end_type, $urandom_range(4, 0));
        repeat ($urandom_range(3, 0)) stream_q.push_back(rand_byte());
        if (pick >= 70) begin
          cut = $urandom_range(stream_q.size() - 1, 1);
          while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
      end else if (pick < 86) begin
        // declared length of up to 0xFFFF, stream ends up to five bytes after the header
        add_header(1'($urandom_range(1, 0)), other_type(),
                   16'($urandom_range(16'hFFFF, 1)));
        repeat ($urandom_range(5, 0)) stream_q.push_back(rand_byte());
      end else begin
        add_record(1'($urandom_range(1, 0)), other_type(), $urandom_range(6, 0));
      end
    end
    send_stream();
  endtask

  task automatic run_random_streams(input int min_items);
    int start;
    start = sent_items;
    while (sent_items - start < min_items) random_stream();
  endtask

  // ---------------------------------------------------------------- tests

  // corner cases with end_record_type still at its reset value of zero
  task automatic test_directed();
    // stream ends after one header byte
    stream_q.push_back(8'hFF);
    send_stream();
    // all-ones header, stream ends inside the body
    add_header(1'b1, 15'h7FFF, 16'hFFFF);
    stream_q.push_back(8'hFF);
    send_stream();
    // empty non-end record completes on the last byte
    add_header(1'b0, 15'h1234, 16'd0);
    send_stream();
    // stream ends on the last header byte of a record with a body
    add_header(1'b1, 15'h0005, 16'd3);
    send_stream();
    // body completes on the last byte, not an end record
    add_header(1'b0, 15'h0007, 16'd1);
    stream_q.push_back(8'h00);
    send_stream();
    // record, end record, then a trailing byte that is dropped
    add_header(1'b0, 15'h0001, 16'd1);
    stream_q.push_back(8'hAA);
    add_header(1'b0, 15'h0000, 16'd0);
    stream_q.push_back(8'h55);
    send_stream();
  endtask

  // random messages under several end types, the extremes among them
  task automatic test_end_type_sweep();
    set_end_type(15'h7FFF);
    run_random_streams(120);
    set_end_type(15'($urandom_range(15'h7FFE, 1)));
    run_random_streams(120);
    set_end_type(15'd1);
    run_random_streams(120);
    set_end_type(15'd0);
    run_random_streams(120);
  endtask

  // end record with a body long enough to use the upper count bits
  task automatic test_long_body();
    add_record(1'($urandom_range(1, 0)), other_type(), $urandom_range(3, 0));
    add_record(1'($urandom_range(1, 0)), active_end_type, $urandom_range(280, 256));
    stream_q.push_back(rand_byte());
    send_stream();
  endtask

  // back-to-back beats on both sides
  task automatic test_no_idle();
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    run_random_streams(120);
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_output_stall();
    int start;
    sender_quiet = 1'b1;
    hold_left    = HOLD_CYCLES;
    start        = sent_items;
    while (sent_items - start < 60) random_stream();
    drain_idle();
    sender_quiet = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 3'd0;
    pwdata        <= 32'd0;
    in_valid_i    <= 1'b0;
    stream_byte_i <= 8'd0;
    stream_end_i  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_end_type_sweep();
    test_long_body();
    test_no_idle();
    test_output_stall();

    drain_idle();
    if (pending_results.size() != 0)
      report_mismatch("results never produced", 32'(pending_results.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== nts_ke_record_stream_parser.f =====
src/nkrp_pkg.sv
src/nkrp_front.sv
src/nkrp_queue.sv
src/nkrp_back.sv
src/nts_ke_record_stream_parser.sv
dv/testbench.sv
